[sv/k_nearest_max_heap_top_macros.svh]
// Assertion macros for the k-nearest max-heap block.
// Used by the checker; expects clk_i and rst_ni in the enclosing scope.
`ifndef K_NEAREST_MAX_HEAP_TOP_MACROS_SVH
`define K_NEAREST_MAX_HEAP_TOP_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define KNN_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define KNN_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/knn_pkg.sv]
// Shared constants and request codes for the k-nearest max-heap block.
// No dependencies.
`timescale 1ns / 1ps

package knn_pkg;

  localparam int unsigned MAX_K_DEF     = 16;
  localparam int unsigned ID_BITS_DEF   = 20;
  localparam int unsigned DIST_BITS_DEF = 32;

  localparam int unsigned CAP_BITS   = 5;
  localparam int unsigned TOTAL_BITS = 5;
  localparam int unsigned REQ_BITS   = 2;

  localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

  typedef enum logic [REQ_BITS-1:0] {
    REQ_INSERT = 2'd0,
    REQ_DUMP   = 2'd1,
    REQ_CLEAR  = 2'd2
  } req_e;

endpackage

[sv/knn_ram.sv]
// Heap entry storage: one write port, two registered read ports.
// Depends on knn_pkg for default widths.
`timescale 1ns / 1ps

module knn_ram import knn_pkg::*; #(
  parameter int unsigned MAX_K     = MAX_K_DEF,
  parameter int unsigned ID_BITS   = ID_BITS_DEF,
  parameter int unsigned DIST_BITS = DIST_BITS_DEF,
  localparam int unsigned AW = (MAX_K > 1) ? $clog2(MAX_K) : 1
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AW-1:0]        waddr_i,
  input  logic [ID_BITS-1:0]   wid_i,
  input  logic [DIST_BITS-1:0] wdist_i,
  input  logic                 re_i,
  input  logic [AW-1:0]        raddr_a_i,
  input  logic [AW-1:0]        raddr_b_i,
  output logic [ID_BITS-1:0]   rid_a_o,
  output logic [DIST_BITS-1:0] rdist_a_o,
  output logic [ID_BITS-1:0]   rid_b_o,
  output logic [DIST_BITS-1:0] rdist_b_o
);

  logic [ID_BITS-1:0]   id_mem   [MAX_K];
  logic [DIST_BITS-1:0] dist_mem [MAX_K];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      id_mem[waddr_i]   <= wid_i;
      dist_mem[waddr_i] <= wdist_i;
    end
  end

  // Read data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rid_a_o   <= id_mem[raddr_a_i];
      rdist_a_o <= dist_mem[raddr_a_i];
      rid_b_o   <= id_mem[raddr_b_i];
      rdist_b_o <= dist_mem[raddr_b_i];
    end
  end

endmodule

[sv/knn_seq.sv]
// Heap sequencer: request decode, sift up / sift down over one shared
// comparator, dump walk and result register. Depends on knn_pkg.
`timescale 1ns / 1ps

module knn_seq import knn_pkg::*; #(
  parameter int unsigned MAX_K     = MAX_K_DEF,
  parameter int unsigned ID_BITS   = ID_BITS_DEF,
  parameter int unsigned DIST_BITS = DIST_BITS_DEF,
  localparam int unsigned AW = (MAX_K > 1) ? $clog2(MAX_K) : 1,
  localparam int unsigned CW = $clog2(MAX_K + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [CW-1:0]         eff_cap_i,
  input  logic                  req_valid_i,
  output logic                  req_ready_o,
  input  logic [REQ_BITS-1:0]   req_type_i,
  input  logic [ID_BITS-1:0]    cand_id_i,
  input  logic [DIST_BITS-1:0]  cand_dist_i,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output logic [ID_BITS-1:0]    out_id_o,
  output logic [DIST_BITS-1:0]  out_dist_o,
  output logic                  out_valid_o,
  output logic                  accepted_o,
  output logic [TOTAL_BITS-1:0] entry_total_o,
  output logic [DIST_BITS-1:0]  worst_dist_o,
  output logic                  heap_full_o,
  output logic                  last_o,
  output logic                  ram_we_o,
  output logic [AW-1:0]         ram_waddr_o,
  output logic [ID_BITS-1:0]    ram_wid_o,
  output logic [DIST_BITS-1:0]  ram_wdist_o,
  output logic                  ram_re_o,
  output logic [AW-1:0]         ram_raddr_a_o,
  output logic [AW-1:0]         ram_raddr_b_o,
  input  logic [ID_BITS-1:0]    ram_rid_a_i,
  input  logic [DIST_BITS-1:0]  ram_rdist_a_i,
  input  logic [ID_BITS-1:0]    ram_rid_b_i,
  input  logic [DIST_BITS-1:0]  ram_rdist_b_i
);

  localparam int unsigned XW = CW + 1;
  localparam int unsigned TW = (CW > TOTAL_BITS) ? CW : TOTAL_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP,
    S_DN_L,
    S_DN_R,
    S_DUMP,
    S_RESP
  } state_e;

  state_e               state_q, state_d;
  logic [AW-1:0]        pos_q, pos_d;
  logic [CW-1:0]        count_q, count_d;
  logic [CW-1:0]        idx_q, idx_d;
  logic [ID_BITS-1:0]   cand_id_q, cand_id_d;
  logic [DIST_BITS-1:0] cand_dist_q, cand_dist_d;
  logic                 big_l_q, big_l_d;
  logic [DIST_BITS-1:0] big_dist_q, big_dist_d;
  logic [DIST_BITS-1:0] root_q, root_d;
  logic                 acc_q, acc_d;

  logic                  res_valid_q;
  logic [ID_BITS-1:0]    res_id_q;
  logic [DIST_BITS-1:0]  res_dist_q;
  logic                  res_ovalid_q;
  logic                  res_acc_q;
  logic [TOTAL_BITS-1:0] res_total_q;
  logic [DIST_BITS-1:0]  res_worst_q;
  logic                  res_full_q;
  logic                  res_last_q;

  logic                 ld;
  logic [ID_BITS-1:0]   ld_id;
  logic [DIST_BITS-1:0] ld_dist;
  logic                 ld_valid;
  logic                 ld_last;
  logic                 slot_free;

  // Shared comparator.
  logic [DIST_BITS-1:0] cmp_a, cmp_b;
  logic                 cmp_gt;

  logic [XW-1:0] n_x, pos_x, l_x, r_x, dn_nl_x, dn_nr_x;
  logic          l_ok, r_ok, take_l, take_r, has_room;
  logic [AW-1:0] par, par_par, dn_next;
  logic [CW-1:0] ins_par, idx_next;
  logic [TW-1:0] count_t;

  assign n_x      = XW'(count_q);
  assign pos_x    = XW'(pos_q);
  assign l_x      = (pos_x << 1) + XW'(1);
  assign r_x      = (pos_x << 1) + XW'(2);
  assign l_ok     = l_x < n_x;
  assign r_ok     = r_x < n_x;
  assign par      = (pos_q - AW'(1)) >> 1;
  assign par_par  = (par - AW'(1)) >> 1;
  assign ins_par  = (count_q - CW'(1)) >> 1;
  assign idx_next = idx_q + CW'(1);
  assign has_room = count_q < eff_cap_i;
  assign count_t  = TW'(count_q);

  assign slot_free   = !res_valid_q || res_ready_i;
  assign req_ready_o = (state_q == S_IDLE);

  // Operand select follows the phase only.
  always_comb begin
    cmp_a = cand_dist_q;
    cmp_b = ram_rdist_a_i;
    case (state_q)
      S_IDLE: begin
        cmp_a = root_q;
        cmp_b = cand_dist_i;
      end
      S_UP: begin
        cmp_a = cand_dist_q;
        cmp_b = ram_rdist_a_i;
      end
      S_DN_L: begin
        cmp_a = ram_rdist_a_i;
        cmp_b = cand_dist_q;
      end
      S_DN_R: begin
        cmp_a = ram_rdist_b_i;
        cmp_b = big_dist_q;
      end
      default: begin
        cmp_a = cand_dist_q;
        cmp_b = ram_rdist_a_i;
      end
    endcase
  end

  assign cmp_gt = cmp_a > cmp_b;

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    count_d     = count_q;
    idx_d       = idx_q;
    cand_id_d   = cand_id_q;
    cand_dist_d = cand_dist_q;
    big_l_d     = big_l_q;
    big_dist_d  = big_dist_q;
    acc_d       = acc_q;

    ram_we_o      = 1'b0;
    ram_waddr_o   = pos_q;
    ram_wid_o     = cand_id_q;
    ram_wdist_o   = cand_dist_q;
    ram_re_o      = 1'b0;
    ram_raddr_a_o = pos_q;
    ram_raddr_b_o = pos_q;

    ld       = 1'b0;
    ld_id    = '0;
    ld_dist  = '0;
    ld_valid = 1'b0;
    ld_last  = 1'b1;

    take_l  = l_ok && cmp_gt;
    take_r  = r_ok && cmp_gt;
    dn_next = take_r ? r_x[AW-1:0] : l_x[AW-1:0];
    dn_nl_x = (XW'(dn_next) << 1) + XW'(1);
    dn_nr_x = (XW'(dn_next) << 1) + XW'(2);

    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          acc_d   = 1'b0;
          state_d = S_RESP;
          case (req_e'(req_type_i))
            REQ_INSERT: begin
              cand_id_d   = cand_id_i;
              cand_dist_d = cand_dist_i;
              if (has_room) begin
                acc_d   = 1'b1;
                count_d = count_q + CW'(1);
                pos_d   = count_q[AW-1:0];
                if (count_q == '0) begin
                  // Empty heap: the candidate becomes the root.
                  ram_we_o    = 1'b1;
                  ram_waddr_o = '0;
                  ram_wid_o   = cand_id_i;
                  ram_wdist_o = cand_dist_i;
                end else begin
                  ram_re_o      = 1'b1;
                  ram_raddr_a_o = ins_par[AW-1:0];
                  state_d       = S_UP;
                end
              end else if (cmp_gt) begin
                // Full and strictly closer than the root: replace root.
                acc_d         = 1'b1;
                pos_d         = '0;
                ram_re_o      = 1'b1;
                ram_raddr_a_o = l_x[AW-1:0];
                ram_raddr_b_o = r_x[AW-1:0];
                ram_raddr_a_o = AW'(XW'(1));
                ram_raddr_b_o = AW'(XW'(2));
                state_d       = S_DN_L;
              end
            end
            REQ_DUMP: begin
              if (count_q != '0) begin
                idx_d         = '0;
                ram_re_o      = 1'b1;
                ram_raddr_a_o = '0;
                state_d       = S_DUMP;
              end
            end
            REQ_CLEAR: begin
              count_d = '0;
            end
            default: begin
              count_d = count_q;
            end
          endcase
        end
      end

      S_UP: begin
        ram_we_o = 1'b1;
        if (pos_q == '0) begin
          state_d = S_RESP;
        end else if (cmp_gt) begin
          // Pull the parent down into the hole and climb.
          ram_wid_o     = ram_rid_a_i;
          ram_wdist_o   = ram_rdist_a_i;
          pos_d         = par;
          ram_re_o      = 1'b1;
          ram_raddr_a_o = par_par;
        end else begin
          state_d = S_RESP;
        end
      end

      S_DN_L: begin
        big_l_d    = take_l;
        big_dist_d = take_l ? ram_rdist_a_i : cand_dist_q;
        state_d    = S_DN_R;
      end

      S_DN_R: begin
        ram_we_o = 1'b1;
        if (take_r || big_l_q) begin
          // Lift the larger child into the hole and descend.
          ram_wid_o     = take_r ? ram_rid_b_i : ram_rid_a_i;
          ram_wdist_o   = take_r ? ram_rdist_b_i : ram_rdist_a_i;
          pos_d         = dn_next;
          ram_re_o      = 1'b1;
          ram_raddr_a_o = dn_nl_x[AW-1:0];
          ram_raddr_b_o = dn_nr_x[AW-1:0];
          state_d       = S_DN_L;
        end else begin
          state_d = S_RESP;
        end
      end

      S_DUMP: begin
        if (slot_free) begin
          ld       = 1'b1;
          ld_id    = ram_rid_a_i;
          ld_dist  = ram_rdist_a_i;
          ld_valid = 1'b1;
          ld_last  = (idx_next == count_q);
          if (idx_next == count_q) begin
            state_d = S_IDLE;
          end else begin
            idx_d         = idx_next;
            ram_re_o      = 1'b1;
            ram_raddr_a_o = idx_next[AW-1:0];
          end
        end
      end

      S_RESP: begin
        if (slot_free) begin
          ld      = 1'b1;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    root_d = (ram_we_o && (ram_waddr_o == '0)) ? ram_wdist_o : root_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      pos_q        <= '0;
      count_q      <= '0;
      idx_q        <= '0;
      cand_id_q    <= '0;
      cand_dist_q  <= '0;
      big_l_q      <= 1'b0;
      big_dist_q   <= '0;
      root_q       <= '0;
      acc_q        <= 1'b0;
      res_valid_q  <= 1'b0;
      res_id_q     <= '0;
      res_dist_q   <= '0;
      res_ovalid_q <= 1'b0;
      res_acc_q    <= 1'b0;
      res_total_q  <= '0;
      res_worst_q  <= '0;
      res_full_q   <= 1'b0;
      res_last_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      cand_id_q   <= cand_id_d;
      cand_dist_q <= cand_dist_d;
      big_l_q     <= big_l_d;
      big_dist_q  <= big_dist_d;
      root_q      <= root_d;
      acc_q       <= acc_d;
      if (ld) begin
        res_valid_q  <= 1'b1;
        res_id_q     <= ld_id;
        res_dist_q   <= ld_dist;
        res_ovalid_q <= ld_valid;
        res_acc_q    <= acc_q;
        res_total_q  <= count_t[TOTAL_BITS-1:0];
        res_worst_q  <= (count_q != '0) ? root_q : '0;
        res_full_q   <= (count_q >= eff_cap_i);
        res_last_q   <= ld_last;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  assign res_valid_o   = res_valid_q;
  assign out_id_o      = res_id_q;
  assign out_dist_o    = res_dist_q;
  assign out_valid_o   = res_ovalid_q;
  assign accepted_o    = res_acc_q;
  assign entry_total_o = res_total_q;
  assign worst_dist_o  = res_worst_q;
  assign heap_full_o   = res_full_q;
  assign last_o        = res_last_q;

endmodule

[sv/k_nearest_max_heap_top.sv]
// Top level of the k-nearest max-heap block: capacity register and
// instances of knn_seq and knn_ram. Depends on knn_pkg.
`timescale 1ns / 1ps

// Keeps the K closest candidates seen so far in a binary max-heap keyed on
// squared distance, so the farthest kept candidate sits at the root and is
// reported as worst_dist_o with every result. Requests arrive on the req
// channel (insert, dump, clear); each produces one result transfer on the
// res channel, except a dump of a non-empty heap, which produces one transfer
// per held entry in array order with last_o on the final one. The capacity
// register is written through the cfg channel, which is always ready; write
// it only while no request is in flight. A capacity of 0 acts as 1 and one
// above MAX_K acts as MAX_K; lowering it below the held count keeps the
// entries and only allows root replacement. The req channel is ready only
// in idle. A clear, a dump of an empty heap, a rejected insert or an insert
// into an empty heap goes straight to the response; an insert into a
// non-empty heap sifts up from the new leaf, a root replacement sifts down
// from the root and a dump walks the held entries, and the response and
// each dumped entry wait while the res side stalls. With K = 16 a sift
// spans at most four levels. The rate is set by the single distance
// comparator, which makes one decision a cycle (two per level on the way
// down, left then right child), and by the heap RAM's single write port. A
// finished result waits in the output register, so the next request is
// taken while it is pending. Storage needs no clearing pass after reset;
// entries at or above the held count are never used.
module k_nearest_max_heap_top import knn_pkg::*; #(
  parameter int unsigned MAX_K     = MAX_K_DEF,
  parameter int unsigned ID_BITS   = ID_BITS_DEF,
  parameter int unsigned DIST_BITS = DIST_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CAP_BITS-1:0]   cfg_data_i,
  // request channel
  input  logic                  req_valid_i,
  output logic                  req_ready_o,
  input  logic [REQ_BITS-1:0]   req_type_i,
  input  logic [ID_BITS-1:0]    cand_id_i,
  input  logic [DIST_BITS-1:0]  cand_dist_i,
  // result channel
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output logic [ID_BITS-1:0]    out_id_o,
  output logic [DIST_BITS-1:0]  out_dist_o,
  output logic                  out_valid_o,
  output logic                  accepted_o,
  output logic [TOTAL_BITS-1:0] entry_total_o,
  output logic [DIST_BITS-1:0]  worst_dist_o,
  output logic                  heap_full_o,
  output logic                  last_o
);

  localparam int unsigned AW = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int unsigned CW = $clog2(MAX_K + 1);
  localparam int unsigned EW = (CW > CAP_BITS) ? CW : CAP_BITS;

  // Capacity register; writes complete in the cycle they are offered.
  logic [CAP_BITS-1:0] cap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_valid_i) begin
      cap_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o = 1'b1;

  // Clamp capacity into 1..MAX_K.
  logic [EW-1:0] cap_x, eff_x;
  logic [CW-1:0] eff_cap;

  assign cap_x   = EW'(cap_q);
  assign eff_x   = (cap_x == '0) ? EW'(1) :
                   (cap_x > EW'(MAX_K)) ? EW'(MAX_K) : cap_x;
  assign eff_cap = eff_x[CW-1:0];

  // Heap RAM connections.
  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_waddr, ram_raddr_a, ram_raddr_b;
  logic [ID_BITS-1:0]   ram_wid, ram_rid_a, ram_rid_b;
  logic [DIST_BITS-1:0] ram_wdist, ram_rdist_a, ram_rdist_b;

  knn_seq #(
    .MAX_K    (MAX_K),
    .ID_BITS  (ID_BITS),
    .DIST_BITS(DIST_BITS)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .eff_cap_i    (eff_cap),
    .req_valid_i  (req_valid_i),
    .req_ready_o  (req_ready_o),
    .req_type_i   (req_type_i),
    .cand_id_i    (cand_id_i),
    .cand_dist_i  (cand_dist_i),
    .res_valid_o  (res_valid_o),
    .res_ready_i  (res_ready_i),
    .out_id_o     (out_id_o),
    .out_dist_o   (out_dist_o),
    .out_valid_o  (out_valid_o),
    .accepted_o   (accepted_o),
    .entry_total_o(entry_total_o),
    .worst_dist_o (worst_dist_o),
    .heap_full_o  (heap_full_o),
    .last_o       (last_o),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wid_o    (ram_wid),
    .ram_wdist_o  (ram_wdist),
    .ram_re_o     (ram_re),
    .ram_raddr_a_o(ram_raddr_a),
    .ram_raddr_b_o(ram_raddr_b),
    .ram_rid_a_i  (ram_rid_a),
    .ram_rdist_a_i(ram_rdist_a),
    .ram_rid_b_i  (ram_rid_b),
    .ram_rdist_b_i(ram_rdist_b)
  );

  knn_ram #(
    .MAX_K    (MAX_K),
    .ID_BITS  (ID_BITS),
    .DIST_BITS(DIST_BITS)
  ) u_ram (
    .clk_i    (clk_i),
    .we_i     (ram_we),
    .waddr_i  (ram_waddr),
    .wid_i    (ram_wid),
    .wdist_i  (ram_wdist),
    .re_i     (ram_re),
    .raddr_a_i(ram_raddr_a),
    .raddr_b_i(ram_raddr_b),
    .rid_a_o  (ram_rid_a),
    .rdist_a_o(ram_rdist_a),
    .rid_b_o  (ram_rid_b),
    .rdist_b_o(ram_rdist_b)
  );

endmodule

[sv/knn_chk.sv]
// Port-level checker for the k-nearest max-heap block, bound to the top.
// Depends on knn_pkg and k_nearest_max_heap_top_macros.svh.
`timescale 1ns / 1ps
`include "k_nearest_max_heap_top_macros.svh"

module knn_chk import knn_pkg::*; #(
  parameter int unsigned ID_BITS   = ID_BITS_DEF,
  parameter int unsigned DIST_BITS = DIST_BITS_DEF
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  req_valid_i,
  input logic                  req_ready_o,
  input logic                  res_valid_o,
  input logic                  res_ready_i,
  input logic [ID_BITS-1:0]    out_id_o,
  input logic [DIST_BITS-1:0]  out_dist_o,
  input logic                  out_valid_o,
  input logic                  accepted_o,
  input logic [TOTAL_BITS-1:0] entry_total_o,
  input logic [DIST_BITS-1:0]  worst_dist_o,
  input logic                  heap_full_o,
  input logic                  last_o
);

  // After an accepted request the sequencer is not ready in the next cycle.
  `KNN_ASSERT_NXT(a_busy_after_req, req_valid_i && req_ready_o, !req_ready_o, "ready after req")

  // A stalled result holds.
  `KNN_ASSERT_NXT(a_res_hold, res_valid_o && !res_ready_i, res_valid_o && $stable(out_id_o) && $stable(out_dist_o) && $stable(last_o) && $stable(heap_full_o), "result changed while stalled")

  // Dumped entries only come from a non-empty heap, never with accepted.
  `KNN_ASSERT(a_dump_nonempty, res_valid_o && out_valid_o, entry_total_o != '0 && !accepted_o, "bad dump result")

  // An empty heap reports a zero root and no entry.
  `KNN_ASSERT(a_empty_root, res_valid_o && entry_total_o == '0, worst_dist_o == '0 && !out_valid_o, "empty heap root")

  // A stored or replacing insert leaves at least one entry; status results carry no entry.
  `KNN_ASSERT(a_acc_status, res_valid_o && accepted_o, entry_total_o != '0 && last_o && out_id_o == '0, "bad insert status")

endmodule

bind k_nearest_max_heap_top knn_chk #(
  .ID_BITS  (ID_BITS),
  .DIST_BITS(DIST_BITS)
) u_knn_chk (.*);
